[src/nps_pkg.sv]
// Package for the nearest point search block: widths, action codes,
// controller states and the command/status structs.
// No dependencies; every other file imports it.
`default_nettype none

package nps_pkg;

	// Field widths of the item channels and the configuration register.
	localparam int COORD_W = 20;
	localparam int TYPE_W = 8;
	localparam int LIMIT_W = 44;
	localparam int OIDX_W = 10;

	// Squared distance widths: |a-b| fits 20 bits, squares 40, the sum 42.
	localparam int ABS_W = COORD_W;
	localparam int SQ_W = 2 * ABS_W;
	localparam int DIST_W = SQ_W + 2;

	// Table depth default and limit register reset (999999.0 with 8 fraction bits).
	localparam int MAX_POINTS_DEF = 1024;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 44'd255999744;

	typedef enum logic [1:0] {
		ACT_CLEAR,
		ACT_ADD,
		ACT_NEAR_ANY,
		ACT_NEAR_TYPE
	} action_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_START,
		ST_SCAN,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// One stored point.
	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		logic [TYPE_W-1:0]  tag;
	} point_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic load;
		logic scan_first;
		logic scan_issue;
		logic result_load;
	} nps_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic is_query;
		logic count_zero;
		logic issue_last;
		logic pipe_busy;
		logic out_free;
	} nps_stat_t;

endpackage

`default_nettype wire

[src/nps_if.sv]
// Valid/ready channel interfaces for the request and the result items.
// Depends on nps_pkg for the field widths.
`default_nettype none

interface nps_req_if;
	import nps_pkg::*;

	logic                      valid;
	logic                      ready;
	logic [1:0]                action;
	logic signed [COORD_W-1:0] pos_x;
	logic signed [COORD_W-1:0] pos_y;
	logic signed [COORD_W-1:0] pos_z;
	logic [TYPE_W-1:0]         point_type;

	modport source (output valid, action, pos_x, pos_y, pos_z, point_type, input ready);
	modport sink (input valid, action, pos_x, pos_y, pos_z, point_type, output ready);
endinterface

interface nps_rsp_if;
	import nps_pkg::*;

	logic              valid;
	logic              ready;
	logic              found;
	logic [OIDX_W-1:0] point_index;
	logic              table_full;

	modport source (output valid, found, point_index, table_full, input ready);
	modport sink (input valid, found, point_index, table_full, output ready);
endinterface

`default_nettype wire

[src/nps_ctrl.sv]
// Controller state machine for the nearest point search block.
// Depends on nps_pkg for the state type and the command/status structs.
`default_nettype none

module nps_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               req_valid,
	output logic                    req_ready,
	input  wire nps_pkg::nps_stat_t stat,
	output nps_pkg::nps_cmd_t       cmd
);
	import nps_pkg::*;

	state_t state_q;
	state_t state_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state and commands.
	always_comb begin
		state_d = state_q;
		req_ready = 1'b0;
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.scan_first = 1'b1;
				if (stat.is_query && !stat.count_zero) begin
					state_d = ST_SCAN;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_SCAN: begin
				cmd.scan_issue = 1'b1;
				if (stat.issue_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!stat.pipe_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (stat.out_free) begin
					cmd.result_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

[src/nps_datapath.sv]
// Datapath of the nearest point search block: point memory, scan pipeline,
// best-distance tracking, point count, limit register and result register.
// Depends on nps_pkg for widths, action codes and the command/status structs.
`default_nettype none

module nps_datapath #(
	parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire nps_pkg::nps_cmd_t           cmd,
	output nps_pkg::nps_stat_t               stat,
	input  wire logic [1:0]                  action,
	input  wire logic [nps_pkg::COORD_W-1:0] pos_x,
	input  wire logic [nps_pkg::COORD_W-1:0] pos_y,
	input  wire logic [nps_pkg::COORD_W-1:0] pos_z,
	input  wire logic [nps_pkg::TYPE_W-1:0]  point_type,
	input  wire logic                        cfg_we,
	input  wire logic [nps_pkg::LIMIT_W-1:0] cfg_wdata,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             found,
	output logic [nps_pkg::OIDX_W-1:0]       point_index,
	output logic                             table_full
);
	import nps_pkg::*;

	localparam int IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

	// Absolute difference of two signed coordinates.
	function automatic logic [ABS_W-1:0] abs_diff(
		input logic [COORD_W-1:0] a,
		input logic [COORD_W-1:0] b
	);
		logic [COORD_W:0] d;
		logic [COORD_W:0] n;
		d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
		n = ~d + 1'b1;
		return d[COORD_W] ? n[ABS_W-1:0] : d[ABS_W-1:0];
	endfunction

	// Latched request, limit and count.
	action_t           act_q;
	point_t            qry_q;
	logic [LIMIT_W-1:0] limit_q;
	logic [CNT_W-1:0]  count_q;
	logic              full;

	// Point memory and scan address.
	point_t            mem [MAX_POINTS];
	logic [IDX_W-1:0]  addr_q;

	// Scan pipeline.
	logic              v_s1, v_s2, v_s3, v_s4;
	point_t            rd_s1;
	logic [IDX_W-1:0]  idx_s1, idx_s2, idx_s3, idx_s4;
	logic [ABS_W-1:0]  ax_s2, ay_s2, az_s2;
	logic [SQ_W-1:0]   sx_s3, sy_s3, sz_s3;
	logic [DIST_W-1:0] dist_s4;
	logic              match;

	// Best candidate so far.
	logic [LIMIT_W-1:0] best_q;
	logic [IDX_W-1:0]   best_idx_q;
	logic               have_q;

	// Result staging.
	logic                  res_found;
	logic [IDX_W-1:0]      res_idx;
	logic                  res_full;
	logic [IDX_W+OIDX_W-1:0] res_idx_ext;

	assign full = (count_q == CNT_MAX);
	assign match = (act_q != ACT_NEAR_TYPE) || (rd_s1.tag == qry_q.tag);

	// Status to the controller.
	always_comb begin
		stat.is_query = (act_q == ACT_NEAR_ANY) || (act_q == ACT_NEAR_TYPE);
		stat.count_zero = (count_q == '0);
		stat.issue_last = ((CNT_W'(addr_q) + 1'b1) == count_q);
		stat.pipe_busy = v_s1 | v_s2 | v_s3 | v_s4;
		stat.out_free = !out_valid || out_ready;
	end

	// Request latch and memory; payload only, no reset.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			act_q <= action_t'(action);
			qry_q <= '{x: pos_x, y: pos_y, z: pos_z, tag: point_type};
		end
		if (cmd.result_load && act_q == ACT_ADD && !full) begin
			mem[count_q[IDX_W-1:0]] <= qry_q;
		end
		if (cmd.scan_issue) begin
			rd_s1 <= mem[addr_q];
		end
	end

	// Scan pipeline payload: differences, squares, sum.
	always_ff @(posedge clk) begin
		idx_s1 <= addr_q;
		idx_s2 <= idx_s1;
		idx_s3 <= idx_s2;
		idx_s4 <= idx_s3;
		ax_s2 <= abs_diff(qry_q.x, rd_s1.x);
		ay_s2 <= abs_diff(qry_q.y, rd_s1.y);
		az_s2 <= abs_diff(qry_q.z, rd_s1.z);
		sx_s3 <= ax_s2 * ax_s2;
		sy_s3 <= ay_s2 * ay_s2;
		sz_s3 <= az_s2 * az_s2;
		dist_s4 <= DIST_W'(sx_s3) + DIST_W'(sy_s3) + DIST_W'(sz_s3);
	end

	// Pipeline valids, scan address, limit register and best candidate.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			addr_q <= '0;
			limit_q <= LIMIT_RESET;
			best_q <= '0;
			best_idx_q <= '0;
			have_q <= 1'b0;
		end else begin
			v_s1 <= cmd.scan_issue;
			v_s2 <= v_s1 && match;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (cmd.scan_first) begin
				addr_q <= '0;
				best_q <= limit_q;
				best_idx_q <= '0;
				have_q <= 1'b0;
			end else begin
				if (cmd.scan_issue) begin
					addr_q <= addr_q + 1'b1;
				end
				// Strictly smaller wins, so ties keep the lower index.
				if (v_s4 && (LIMIT_W'(dist_s4) < best_q)) begin
					best_q <= LIMIT_W'(dist_s4);
					best_idx_q <= idx_s4;
					have_q <= 1'b1;
				end
			end
		end
	end

	// Result of the current item.
	always_comb begin
		res_found = 1'b0;
		res_idx = '0;
		res_full = 1'b0;
		case (act_q)
			ACT_CLEAR: begin
				res_found = 1'b0;
			end
			ACT_ADD: begin
				res_found = !full;
				res_full = full;
				res_idx = full ? '0 : count_q[IDX_W-1:0];
			end
			ACT_NEAR_ANY, ACT_NEAR_TYPE: begin
				res_found = have_q;
				res_idx = have_q ? best_idx_q : '0;
			end
			default: begin
				res_found = 1'b0;
			end
		endcase
		res_idx_ext = {{OIDX_W{1'b0}}, res_idx};
	end

	// Point count and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			out_valid <= 1'b0;
		end else begin
			if (cmd.result_load) begin
				out_valid <= 1'b1;
				if (act_q == ACT_CLEAR) begin
					count_q <= '0;
				end else if (act_q == ACT_ADD && !full) begin
					count_q <= count_q + 1'b1;
				end
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// Output payload; no reset needed.
	always_ff @(posedge clk) begin
		if (cmd.result_load) begin
			found <= res_found;
			point_index <= res_idx_ext[OIDX_W-1:0];
			table_full <= res_full;
		end
	end

endmodule

`default_nettype wire

[src/nearest_point_search.sv]
// Nearest point search over a table of typed 3D points.
//
// Request channel (req): action 0 clears the table, 1 adds a point at the next
// free index, 2 finds the nearest stored point, 3 finds the nearest point whose
// tag equals point_type. Result channel (rsp): exactly one item per request,
// carrying found, point_index and table_full.
// Configuration: cfg_we writes cfg_wdata into the squared distance limit; only
// points strictly nearer than the limit can be chosen. Write it only while idle.
//
// Timing: one request is in flight at a time. Clear and add pass from
// acceptance through the start and done states to the result register. A
// query scans the stored points one per cycle through a single-port point
// memory and a distance pipeline of read, difference, square and sum stages.
// The next request is taken the cycle after a result is registered.
// The result sits in an output register: a new request is taken while a result
// still waits, and the block holds in its final state while rsp is stalled.
// Reset clears the point count (the table is empty), loads the default limit
// and empties the result register; the point memory itself is not cleared.
// Depends on nps_pkg, nps_if, nps_ctrl and nps_datapath.
`default_nettype none

module nearest_point_search #(
	parameter int MAX_POINTS = nps_pkg::MAX_POINTS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	nps_req_if.sink                          req,
	nps_rsp_if.source                        rsp,
	input  wire logic                        cfg_we,
	input  wire logic [nps_pkg::LIMIT_W-1:0] cfg_wdata
);
	import nps_pkg::*;

	nps_cmd_t  cmd;
	nps_stat_t stat;
	logic      req_ready;

	assign req.ready = req_ready;

	// Sequencing of load, scan and result.
	nps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Storage, distance pipeline and result register.
	nps_datapath #(
		.MAX_POINTS (MAX_POINTS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.action      (req.action),
		.pos_x       (req.pos_x),
		.pos_y       (req.pos_y),
		.pos_z       (req.pos_z),
		.point_type  (req.point_type),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.out_valid   (rsp.valid),
		.out_ready   (rsp.ready),
		.found       (rsp.found),
		.point_index (rsp.point_index),
		.table_full  (rsp.table_full)
	);

endmodule

`default_nettype wire

[tb/nps_checker.sv]
// Result checker for the nearest point search block: watches the request,
// result and configuration ports, predicts every result and compares it.
// Depends on nps_pkg and on the nps_req_if / nps_rsp_if interfaces.
`timescale 1ns / 1ps

module nps_checker
	import nps_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	nps_req_if                      req,
	nps_rsp_if                      rsp,
	input  wire logic               cfg_we,
	input  wire logic [LIMIT_W-1:0] cfg_wdata,
	output int                      mismatches,
	output int                      results_seen,
	output int                      open_results
);

	typedef struct packed {
		logic              found;
		logic [OIDX_W-1:0] slot;
		logic              full;
	} outcome_t;

	// Our own copy of the point table, its fill level and the distance limit.
	logic signed [COORD_W-1:0] tab_x [MAX_POINTS_DEF];
	logic signed [COORD_W-1:0] tab_y [MAX_POINTS_DEF];
	logic signed [COORD_W-1:0] tab_z [MAX_POINTS_DEF];
	logic [TYPE_W-1:0]         tab_tag [MAX_POINTS_DEF];
	int                        stored;
	logic [LIMIT_W-1:0]        dist_limit;
	outcome_t                  awaited [$];
	int                        faults;

	function automatic longint axis_sq(logic signed [COORD_W-1:0] a, b);
		longint d;
		d = longint'(a) - longint'(b);
		return d * d;
	endfunction

	// Updates the table for clear and add, and scans it for a query.
	function automatic outcome_t apply_request(action_t act,
			logic signed [COORD_W-1:0] qx, qy, qz, logic [TYPE_W-1:0] tag);
		outcome_t res;
		longint   best;
		longint   d;
		int       i;
		res = '0;
		case (act)
			ACT_CLEAR: begin
				stored = 0;
			end
			ACT_ADD: begin
				if (stored >= MAX_POINTS_DEF) begin
					res.full = 1'b1;
				end else begin
					tab_x[stored] = qx;
					tab_y[stored] = qy;
					tab_z[stored] = qz;
					tab_tag[stored] = tag;
					res.found = 1'b1;
					res.slot = OIDX_W'(stored);
					stored++;
				end
			end
			default: begin
				// Strictly below the limit, and the first of equal distances wins.
				best = longint'(dist_limit);
				for (i = 0; i < stored; i++) begin
					if (act == ACT_NEAR_TYPE && tab_tag[i] != tag)
						continue;
					d = axis_sq(qx, tab_x[i]) + axis_sq(qy, tab_y[i]) + axis_sq(qz, tab_z[i]);
					if (d < best) begin
						best = d;
						res.found = 1'b1;
						res.slot = OIDX_W'(i);
					end
				end
			end
		endcase
		return res;
	endfunction

	task automatic report(string what, int want, int got);
		$display("%0t ns: result %s mismatch, expected %0d, actual %0d", $time, what, want, got);
		faults++;
	endtask

	// Register writes, result comparison and prediction, all on the clock edge.
	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		outcome_t got;
		outcome_t fresh;
		if (!arst_n) begin
			stored = 0;
			dist_limit = LIMIT_RESET;
			awaited.delete();
			faults = 0;
			mismatches <= 0;
			results_seen <= 0;
			open_results <= 0;
		end else begin
			if (cfg_we)
				dist_limit = cfg_wdata;
			if (rsp.valid && rsp.ready) begin
				got = '{found: rsp.found, slot: rsp.point_index, full: rsp.table_full};
				if (awaited.size() == 0) begin
					$display("%0t ns: result item with no request pending, actual %0d/%0d/%0d",
						$time, got.found, got.slot, got.full);
					faults++;
				end else begin
					want = awaited.pop_front();
					if (got.found !== want.found)
						report("found", want.found, got.found);
					if (got.slot !== want.slot)
						report("point_index", want.slot, got.slot);
					if (got.full !== want.full)
						report("table_full", want.full, got.full);
				end
				results_seen <= results_seen + 1;
			end
			if (req.valid && req.ready) begin
				fresh = apply_request(action_t'(req.action), req.pos_x, req.pos_y,
					req.pos_z, req.point_type);
				awaited = {awaited, fresh};
			end
			open_results <= awaited.size();
			mismatches <= faults;
		end
	end

endmodule

[tb/testbench.sv]
// Top of the nearest point search testbench: clock, reset, request stimulus,
// result back-pressure and the verdict. Uses nps_pkg, the channel interfaces,
// the nearest_point_search block and the nps_checker module.
`timescale 1ns / 1ps

module testbench;
	import nps_pkg::*;

	localparam logic signed [COORD_W-1:0] C_MAX = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic signed [COORD_W-1:0] C_MIN = {1'b1, {(COORD_W-1){1'b0}}};
	localparam logic signed [COORD_W-1:0] C_ONE = COORD_W'(16);
	localparam logic signed [COORD_W-1:0] C_ZERO = '0;
	localparam logic [LIMIT_W-1:0] LIMIT_TOP = '1;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [LIMIT_W-1:0] cfg_wdata;
	logic calm;
	int mismatches;
	int results_seen;
	int open_results;
	int items_sent;
	int table_fill;
	logic signed [COORD_W-1:0] last_x, last_y, last_z;
	logic [TYPE_W-1:0] tag_pool [4];

	nps_req_if req_ch ();
	nps_rsp_if rsp_ch ();

	nearest_point_search u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	nps_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.mismatches(mismatches),
		.results_seen(results_seen),
		.open_results(open_results)
	);

	// 8 ns clock.
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Guard against a hang.
	initial begin
		#32000000;
		$display("** nearest_point_search: FAILED **");
		$finish;
	end

	// Offers one request item and waits until it is taken.
	task automatic send_req(action_t act, logic signed [COORD_W-1:0] x, y, z,
			logic [TYPE_W-1:0] tag);
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.pos_x <= x;
		req_ch.pos_y <= y;
		req_ch.pos_z <= z;
		req_ch.point_type <= tag;
		do @(posedge clk); while (!req_ch.ready);
		items_sent++;
		if (act == ACT_CLEAR) begin
			table_fill = 0;
		end else if (act == ACT_ADD && table_fill < MAX_POINTS_DEF) begin
			table_fill++;
			last_x = x;
			last_y = y;
			last_z = z;
		end
	endtask

	task automatic pause(int cycles);
		req_ch.valid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	task automatic maybe_pause(int pct);
		if (!calm && $urandom_range(0, 99) < pct)
			pause($urandom_range(1, 18));
	endtask

	// Waits until every request has its result back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (results_seen < items_sent) @(posedge clk);
	endtask

	task automatic set_limit(logic [LIMIT_W-1:0] lim);
		cfg_we <= 1'b1;
		cfg_wdata <= lim;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Mostly near the origin so that distances straddle the limit.
	function automatic logic signed [COORD_W-1:0] pick_coord(int spread);
		if ($urandom_range(0, 4) == 0)
			return COORD_W'($urandom);
		return COORD_W'(int'($urandom_range(0, 2 * spread)) - spread);
	endfunction

	// Small tables built and queried with random content under one limit.
	task automatic random_phase(logic [LIMIT_W-1:0] lim, int spread, int gap_pct, int count);
		int cap;
		int roll;
		int k;
		logic [TYPE_W-1:0] tag;
		action_t act;
		drain();
		set_limit(lim);
		for (k = 0; k < 4; k++)
			tag_pool[k] = TYPE_W'($urandom);
		cap = $urandom_range(8, 48);
		for (k = 0; k < count; k++) begin
			roll = $urandom_range(0, 99);
			if (table_fill >= cap)
				act = roll < 12 ? ACT_CLEAR : (roll < 55 ? ACT_NEAR_ANY : ACT_NEAR_TYPE);
			else if (roll < 45)
				act = ACT_ADD;
			else if (roll < 70)
				act = ACT_NEAR_TYPE;
			else if (roll < 95)
				act = ACT_NEAR_ANY;
			else
				act = ACT_CLEAR;
			tag = $urandom_range(0, 99) < 85 ? tag_pool[$urandom_range(0, 3)] : TYPE_W'($urandom);
			// Repeat the last position now and then: exact hits and ties.
			if (act != ACT_CLEAR && table_fill > 0 && $urandom_range(0, 5) == 0)
				send_req(act, last_x, last_y, last_z, tag);
			else
				send_req(act, pick_coord(spread), pick_coord(spread), pick_coord(spread), tag);
			maybe_pause(gap_pct);
			if (act == ACT_CLEAR)
				cap = $urandom_range(8, 48);
		end
	endtask

	// Result side: random stalls, one long hold-off, none once calm.
	initial begin : rsp_sink
		int taken;
		int hold;
		bit held_off;
		rsp_ch.ready <= 1'b0;
		taken = 0;
		held_off = 1'b0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			if (!calm && !held_off && taken >= 300) begin
				held_off = 1'b1;
				rsp_ch.ready <= 1'b0;
				repeat (400) @(posedge clk);
			end else if (!calm && $urandom_range(0, 9) == 0) begin
				rsp_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 18)) @(posedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
				hold = calm ? 1 : $urandom_range(1, 60);
				repeat (hold) begin
					@(posedge clk);
					if (rsp_ch.valid && rsp_ch.ready)
						taken++;
				end
			end
		end
	end

	// Request side: reset, directed items, random phases, verdict.
	initial begin : stimulus
		int ph;
		int spread;
		int gap;
		logic [LIMIT_W-1:0] lim;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		calm <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_CLEAR;
		req_ch.pos_x <= '0;
		req_ch.pos_y <= '0;
		req_ch.pos_z <= '0;
		req_ch.point_type <= '0;
		items_sent = 0;
		table_fill = 0;
		last_x = '0;
		last_y = '0;
		last_z = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Queries on an empty table find nothing.
		send_req(ACT_NEAR_ANY, C_ZERO, C_ZERO, C_ZERO, '0);
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, '0);
		// Corners, the origin and three points at equal distance from it.
		send_req(ACT_ADD, C_ZERO, C_ZERO, C_ZERO, 8'h00);
		send_req(ACT_ADD, C_MAX, C_MAX, C_MAX, 8'hFF);
		send_req(ACT_ADD, C_MIN, C_MIN, C_MIN, 8'hA5);
		send_req(ACT_ADD, C_ONE, C_ZERO, C_ZERO, 8'h5A);
		send_req(ACT_ADD, -C_ONE, C_ZERO, C_ZERO, 8'h5A);
		send_req(ACT_ADD, C_ZERO, C_ONE, C_ZERO, 8'h5A);
		send_req(ACT_NEAR_ANY, C_ZERO, C_ZERO, C_ZERO, '0);
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'h5A);
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'hFF);
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'h77);
		send_req(ACT_NEAR_ANY, C_MAX, C_MAX, C_MAX, '0);
		send_req(ACT_NEAR_TYPE, C_MIN, C_MIN, C_MIN, 8'hA5);
		send_req(ACT_NEAR_ANY, C_MIN, C_MAX, C_MIN, '0);
		// Widest limit: even the opposite corner is in range.
		drain();
		set_limit(LIMIT_TOP);
		send_req(ACT_NEAR_TYPE, C_MAX, C_MAX, C_MAX, 8'hA5);
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'hFF);
		// A zero limit rejects even an exact hit.
		drain();
		set_limit('0);
		send_req(ACT_NEAR_ANY, C_ZERO, C_ZERO, C_ZERO, '0);
		// A distance equal to the limit does not count, one below it does.
		drain();
		set_limit(LIMIT_W'(256));
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'h5A);
		drain();
		set_limit(LIMIT_W'(257));
		send_req(ACT_NEAR_TYPE, C_ZERO, C_ZERO, C_ZERO, 8'h5A);
		send_req(ACT_CLEAR, C_MAX, C_MIN, C_MAX, 8'hFF);
		send_req(ACT_NEAR_ANY, C_ZERO, C_ZERO, C_ZERO, '0);
		send_req(ACT_ADD, C_ONE, C_ONE, C_ONE, 8'h01);
		send_req(ACT_NEAR_ANY, C_ONE, C_ONE, C_ONE, '0);

		for (ph = 0; ph < 7; ph++) begin
			case (ph)
				0: lim = LIMIT_RESET;
				1: lim = LIMIT_W'($urandom_range(0, 1 << 20));
				2: lim = '0;
				3: lim = LIMIT_W'($urandom_range(0, 1 << 16));
				4: lim = LIMIT_TOP;
				5: lim = LIMIT_W'({$urandom, $urandom});
				default: lim = LIMIT_W'($urandom_range(1 << 10, 1 << 22));
			endcase
			spread = ph % 3 == 0 ? 64 : (ph % 3 == 1 ? 512 : 8192);
			// The sender keeps pushing in the phase where the long hold-off lands.
			gap = ph == 3 ? 0 : (ph % 2 == 1 ? 10 : 35);
			random_phase(lim, spread, gap, 72);
		end

		// Last stretch runs with no idling on either side.
		calm <= 1'b1;
		random_phase(LIMIT_W'($urandom_range(1 << 14, 1 << 20)), 512, 0, 72);

		drain();
		repeat (1100) @(posedge clk);
		if (mismatches == 0 && open_results == 0) begin
			$display("** nearest_point_search: PASSED **");
		end else begin
			$display("** nearest_point_search: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
src/nps_pkg.sv
src/nps_if.sv
src/nps_ctrl.sv
src/nps_datapath.sv
src/nearest_point_search.sv
tb/nps_checker.sv
tb/testbench.sv
